@@ rtl/i2cbb_pkg.sv @@
package i2cbb_pkg;

    // operation codes, equal to the command codes that start them
    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4,
        OP_RECOVER = 3'd5
    } op_t;

    // configuration register indexes
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_SETTLE      = 2'd1;

    // configuration reset values
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [23:0] SETTLE_RESET      = 24'd20000;

    // default number of scl pulses during bus recovery
    localparam int RECOVERY_PULSES_DEF = 16;

    // phase in which recovery waits for the bus to settle
    localparam logic [2:0] PH_SETTLE = 3'd6;

endpackage

@@ rtl/i2c_bitbang_master_engine_core.sv @@
// Open-drain I2C master bit engine with bus recovery.
// Input channel (s_*): one item per time tick. s_tuser carries the command
// (0 tick only, 1 start, 2 stop, 3 write byte, 4 read byte, 5 recover bus);
// s_tdata carries the byte to send, the NACK request for reads and the
// sampled SDA level. Commands are taken only while the engine is idle.
// Result channel (m_*): exactly one result item per input item, giving the
// SCL/SDA pull-down drives, busy and done flags, the last write ACK, the
// last read byte and the recovery outcome.
// Config channel (cfg_*): register 0 is the half period in ticks, register
// 1 the settle wait after the recovery STOP; always ready. The user writes it only
// while idle, which the block does not enforce. The result of an item sits in the
// output register on the cycle after it is accepted. Throughput is one item per
// clock while the receiver does not stall, set by the single state update between
// the input handshake and the output register. When the receiver stalls, the
// output register holds its item and s_tready drops until that item is taken (an
// item is taken on the same edge as the result leaves). Reset releases both lines, idles
// the engine and restores the configuration defaults (half period 100, settle 20000).
module i2c_bitbang_master_engine_core #(
    parameter int RECOVERY_PULSES = i2cbb_pkg::RECOVERY_PULSES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] nack_last, [9] sda_in, zero fill
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_drive_low, [1] sda_drive_low, [2] busy_res,
                                   // [3] done_res, [4] ack_seen, [12:5] read_data,
                                   // [13] bus_ok, zero fill
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int PW = $clog2(RECOVERY_PULSES + 1);
    localparam logic [PW-1:0] PULSE_MAX = PW'(RECOVERY_PULSES);

    // input fields
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       nack_last;
    logic       sda_in;
    logic       s_fire;

    assign cmd       = s_tuser;
    assign data_byte = s_tdata[7:0];
    assign nack_last = s_tdata[8];
    assign sda_in    = s_tdata[9];
    assign s_tready  = !m_tvalid || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    // configuration registers
    logic [15:0] half_reg;
    logic [23:0] settle_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg       <= i2cbb_pkg::HALF_PERIOD_RESET;
            settle_cfg_reg <= i2cbb_pkg::SETTLE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == i2cbb_pkg::REG_HALF_PERIOD) half_reg <= cfg_data[15:0];
            else if (cfg_index == i2cbb_pkg::REG_SETTLE) settle_cfg_reg <= cfg_data;
        end
    end

    // sequencer state
    i2cbb_pkg::op_t op_reg, op_next;
    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    bit_reg, bit_next;
    logic [15:0]   delay_reg, delay_next;
    logic [23:0]   settle_reg, settle_next;
    logic [7:0]    shift_reg, shift_next;
    logic [PW-1:0] pulse_reg, pulse_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;
    logic          ack_reg, ack_next;
    logic          ok_reg, ok_next;
    logic [7:0]    rd_reg, rd_next;
    logic          nack_reg, nack_next;
    logic          done;
    logic          enter;
    logic [2:0]    enter_ph;

    // one tick of the sequencer: phase end actions, then entry of the next phase
    always_comb begin
        op_next     = op_reg;
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        delay_next  = delay_reg;
        settle_next = settle_reg;
        shift_next  = shift_reg;
        pulse_next  = pulse_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        ack_next    = ack_reg;
        ok_next     = ok_reg;
        rd_next     = rd_reg;
        nack_next   = nack_reg;
        done        = 1'b0;
        enter       = 1'b0;
        enter_ph    = 3'd0;

        if (op_reg == i2cbb_pkg::OP_IDLE) begin
            // new command
            if (cmd inside {[i2cbb_pkg::OP_START:i2cbb_pkg::OP_RECOVER]}) begin
                op_next    = i2cbb_pkg::op_t'(cmd);
                bit_next   = 3'd0;
                pulse_next = '0;
                if (cmd == i2cbb_pkg::OP_WRITE) shift_next = data_byte;
                if (cmd == i2cbb_pkg::OP_READ) begin
                    shift_next = 8'd0;
                    nack_next  = nack_last;
                end
                enter    = 1'b1;
                enter_ph = 3'd0;
            end
        end else if (op_reg == i2cbb_pkg::OP_RECOVER && phase_reg == i2cbb_pkg::PH_SETTLE) begin
            // settle wait, then sample sda
            if (settle_reg != 24'd0) begin
                settle_next = settle_reg - 24'd1;
            end else begin
                ok_next = sda_in;
                op_next = i2cbb_pkg::OP_IDLE;
                done    = 1'b1;
            end
        end else if (delay_reg > 16'd1) begin
            delay_next = delay_reg - 16'd1;
        end else begin
            // end of the current phase
            case (op_reg)
                i2cbb_pkg::OP_START, i2cbb_pkg::OP_STOP: begin
                    if (phase_reg >= 3'd2) begin
                        done = 1'b1;
                    end else begin
                        enter    = 1'b1;
                        enter_ph = phase_reg + 3'd1;
                    end
                end
                i2cbb_pkg::OP_WRITE: begin
                    if (phase_reg == 3'd2) begin
                        enter = 1'b1;
                        if (bit_reg != 3'd7) begin
                            bit_next = bit_reg + 3'd1;
                            enter_ph = 3'd0;
                        end else begin
                            enter_ph = 3'd3;
                        end
                    end else if (phase_reg == 3'd4) begin
                        ack_next = !sda_in;
                        enter    = 1'b1;
                        enter_ph = 3'd5;
                    end else if (phase_reg >= 3'd5) begin
                        done = 1'b1;
                    end else begin
                        enter    = 1'b1;
                        enter_ph = phase_reg + 3'd1;
                    end
                end
                i2cbb_pkg::OP_READ: begin
                    if (phase_reg == 3'd0) begin
                        shift_next = {shift_reg[6:0], sda_in};
                        enter      = 1'b1;
                        enter_ph   = 3'd1;
                    end else if (phase_reg == 3'd1) begin
                        enter = 1'b1;
                        if (bit_reg != 3'd7) begin
                            bit_next = bit_reg + 3'd1;
                            enter_ph = 3'd0;
                        end else begin
                            enter_ph = 3'd2;
                        end
                    end else if (phase_reg == 3'd2) begin
                        enter    = 1'b1;
                        enter_ph = 3'd3;
                    end else begin
                        scl_next = 1'b1;
                        sda_next = 1'b0;
                        rd_next  = shift_reg;
                        done     = 1'b1;
                    end
                end
                default: begin
                    // recovery
                    if (phase_reg == 3'd0) begin
                        enter = 1'b1;
                        if (!sda_in) begin
                            pulse_next = '0;
                            enter_ph   = 3'd1;
                        end else begin
                            enter_ph = 3'd3;
                        end
                    end else if (phase_reg == 3'd2) begin
                        pulse_next = pulse_reg + PW'(1);
                        enter      = 1'b1;
                        if (sda_in || pulse_next >= PULSE_MAX) enter_ph = 3'd3;
                        else enter_ph = 3'd1;
                    end else begin
                        enter    = 1'b1;
                        enter_ph = phase_reg + 3'd1;
                    end
                end
            endcase
            if (done) begin
                op_next    = i2cbb_pkg::OP_IDLE;
                phase_next = 3'd0;
            end
        end

        // phase entry: load the delay and set the line drives
        if (enter) begin
            phase_next = enter_ph;
            delay_next = (half_reg != 16'd0) ? half_reg : 16'd1;
            case (op_next)
                i2cbb_pkg::OP_START: begin
                    if (enter_ph == 3'd0) begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end else if (enter_ph == 3'd1) begin
                        sda_next = 1'b1;
                    end else begin
                        scl_next = 1'b1;
                    end
                end
                i2cbb_pkg::OP_STOP: begin
                    if (enter_ph == 3'd0) sda_next = 1'b1;
                    else if (enter_ph == 3'd1) scl_next = 1'b0;
                    else sda_next = 1'b0;
                end
                i2cbb_pkg::OP_WRITE: begin
                    if (enter_ph == 3'd0) sda_next = !shift_next[3'd7 - bit_next];
                    else if (enter_ph == 3'd1) scl_next = 1'b0;
                    else if (enter_ph == 3'd2) scl_next = 1'b1;
                    else if (enter_ph == 3'd3) sda_next = 1'b0;
                    else if (enter_ph == 3'd4) scl_next = 1'b0;
                    else scl_next = 1'b1;
                end
                i2cbb_pkg::OP_READ: begin
                    if (enter_ph == 3'd0) begin
                        sda_next = 1'b0;
                        scl_next = 1'b0;
                    end else if (enter_ph == 3'd1) begin
                        scl_next = 1'b1;
                    end else if (enter_ph == 3'd2) begin
                        sda_next = !nack_next;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                default: begin
                    if (enter_ph == 3'd0) begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end else if (enter_ph == 3'd1) begin
                        scl_next = 1'b1;
                    end else if (enter_ph == 3'd2) begin
                        scl_next = 1'b0;
                    end else if (enter_ph == 3'd3) begin
                        sda_next = 1'b1;
                    end else if (enter_ph == 3'd4) begin
                        scl_next = 1'b0;
                    end else if (enter_ph == 3'd5) begin
                        sda_next = 1'b0;
                    end else begin
                        settle_next = settle_cfg_reg;
                    end
                end
            endcase
        end
    end

    // state update on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg     <= i2cbb_pkg::OP_IDLE;
            phase_reg  <= 3'd0;
            bit_reg    <= 3'd0;
            delay_reg  <= 16'd0;
            settle_reg <= 24'd0;
            shift_reg  <= 8'd0;
            pulse_reg  <= '0;
            scl_reg    <= 1'b0;
            sda_reg    <= 1'b0;
            ack_reg    <= 1'b0;
            ok_reg     <= 1'b0;
            rd_reg     <= 8'd0;
            nack_reg   <= 1'b0;
        end else if (s_fire) begin
            op_reg     <= op_next;
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            delay_reg  <= delay_next;
            settle_reg <= settle_next;
            shift_reg  <= shift_next;
            pulse_reg  <= pulse_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            ack_reg    <= ack_next;
            ok_reg     <= ok_next;
            rd_reg     <= rd_next;
            nack_reg   <= nack_next;
        end
    end

    // output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= {2'b00, ok_next, rd_next, ack_next, done,
                           (op_next != i2cbb_pkg::OP_IDLE), sda_next, scl_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a finishing tick always leaves the engine idle
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done reported while still busy");

    // a valid command on an idle engine starts an operation
    a_cmd_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && op_reg == i2cbb_pkg::OP_IDLE &&
         cmd >= i2cbb_pkg::OP_START && cmd <= i2cbb_pkg::OP_RECOVER)
        |=> op_reg != i2cbb_pkg::OP_IDLE)
        else $error("command accepted while idle did not start");

    // a timed phase never runs with an empty delay counter
    a_delay_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg != i2cbb_pkg::OP_IDLE &&
         !(op_reg == i2cbb_pkg::OP_RECOVER && phase_reg == i2cbb_pkg::PH_SETTLE))
        |-> delay_reg != 16'd0)
        else $error("phase delay counter is zero while busy");

    // recovery pulse count stays within its limit
    a_pulse_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_reg <= PULSE_MAX)
        else $error("recovery pulse count out of range");

endmodule

@@ sim/i2c_bitbang_master_engine_core_tb.sv @@
module i2c_bitbang_master_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // command codes that start nothing
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    // command codes that start an operation
    localparam logic [2:0] CMD_START   = i2cbb_pkg::OP_START;
    localparam logic [2:0] CMD_STOP    = i2cbb_pkg::OP_STOP;
    localparam logic [2:0] CMD_WRITE   = i2cbb_pkg::OP_WRITE;
    localparam logic [2:0] CMD_READ    = i2cbb_pkg::OP_READ;
    localparam logic [2:0] CMD_RECOVER = i2cbb_pkg::OP_RECOVER;

    // sda release point meaning the line is held low for the whole operation
    localparam int NEVER_REL = 32'h7FFF_FFFF;

    localparam int RANDOM_ITEMS = 200;
    localparam int MAX_REPORTS  = 40;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser   = '0;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    i2c_bitbang_master_engine_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // engine mirror: configuration and sequencer state
    logic [15:0]    half_cfg   = i2cbb_pkg::HALF_PERIOD_RESET;
    logic [23:0]    settle_cfg = i2cbb_pkg::SETTLE_RESET;
    i2cbb_pkg::op_t eng_op     = i2cbb_pkg::OP_IDLE;
    logic [3:0]     ph         = '0;
    logic [3:0]     bit_idx    = '0;
    logic [15:0]    dly        = '0;
    logic [23:0]    settle_cnt = '0;
    logic [7:0]     shreg      = '0;
    logic [4:0]     pulses     = '0;
    logic           scl_lo     = 1'b0;
    logic           sda_lo     = 1'b0;
    logic           ack_r      = 1'b0;
    logic           ok_r       = 1'b0;
    logic [7:0]     rd_byte    = '0;
    logic           nack_r     = 1'b0;

    // bus results still to come out of the block, oldest first
    logic [15:0] bus_result_q [$];

    int  err_count  = 0;
    int  items_sent = 0;
    int  stall_left = 0;
    bit  idle_en    = 1'b1;

    // directed stimulus, one operation per row
    typedef struct packed {
        bit          set_cfg;
        logic [15:0] half;
        logic [23:0] settle;
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic        nack;
        bit          sda_rand;
        int          release_at;
        bit          noisy;
        bit          typed;
        logic [15:0] typed_res;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [0:19] = '{
        // idle after reset, unknown commands ignored
        '{1'b0, 16'd0, 24'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, NEVER_REL, 1'b0, 1'b1, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_UNUSED_A, 8'hFF, 1'b1, 1'b0, 0, 1'b0, 1'b1, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_UNUSED_B, 8'hFF, 1'b1, 1'b0, 0, 1'b0, 1'b1, 16'h0},
        // start at the reset half period
        '{1'b0, 16'd0, 24'd0, CMD_START, 8'h00, 1'b0, 1'b0, 0, 1'b0, 1'b0, 16'h0},
        // zero half period, zero settle
        '{1'b1, 16'd0, 24'd0, CMD_WRITE, 8'hA5, 1'b0, 1'b0, NEVER_REL, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_WRITE, 8'h00, 1'b0, 1'b0, 0, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_WRITE, 8'hFF, 1'b1, 1'b1, 0, 1'b1, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_READ, 8'h00, 1'b0, 1'b0, 0, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_READ, 8'hFF, 1'b1, 1'b0, NEVER_REL, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_READ, 8'h3C, 1'b0, 1'b1, 0, 1'b1, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_STOP, 8'h00, 1'b0, 1'b0, 0, 1'b0, 1'b0, 16'h0},
        // recovery with sda already high skips the pulses
        '{1'b0, 16'd0, 24'd0, CMD_RECOVER, 8'h00, 1'b0, 1'b0, 0, 1'b0, 1'b0, 16'h0},
        // stuck sda: all pulses, then bus reported bad
        '{1'b1, 16'd1, 24'd3, CMD_RECOVER, 8'h00, 1'b0, 1'b0, NEVER_REL, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_RECOVER, 8'h00, 1'b0, 1'b0, 9, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_RECOVER, 8'h00, 1'b0, 1'b1, 0, 1'b1, 1'b0, 16'h0},
        '{1'b1, 16'd2, 24'd1, CMD_START, 8'h00, 1'b0, 1'b1, 0, 1'b1, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_WRITE, 8'h5A, 1'b0, 1'b1, 0, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_READ, 8'h00, 1'b1, 1'b1, 0, 1'b0, 1'b0, 16'h0},
        '{1'b0, 16'd0, 24'd0, CMD_STOP, 8'h00, 1'b0, 1'b1, 0, 1'b1, 1'b0, 16'h0},
        '{1'b1, 16'd1, 24'd0, CMD_RECOVER, 8'h00, 1'b0, 1'b0, 40, 1'b0, 1'b0, 16'h0}
    };

    // line drives and timer load on entry to a phase
    function automatic void enter_phase(int p);
        ph  = 4'(p);
        dly = (half_cfg != 16'd0) ? half_cfg : 16'd1;
        case (eng_op)
            i2cbb_pkg::OP_START: begin
                if (p == 0) begin
                    scl_lo = 1'b0;
                    sda_lo = 1'b0;
                end else if (p == 1) begin
                    sda_lo = 1'b1;
                end else begin
                    scl_lo = 1'b1;
                end
            end
            i2cbb_pkg::OP_STOP: begin
                if (p == 0) sda_lo = 1'b1;
                else if (p == 1) scl_lo = 1'b0;
                else sda_lo = 1'b0;
            end
            i2cbb_pkg::OP_WRITE: begin
                if (p == 0) sda_lo = ~shreg[7 - bit_idx[2:0]];
                else if (p == 1) scl_lo = 1'b0;
                else if (p == 2) scl_lo = 1'b1;
                else if (p == 3) sda_lo = 1'b0;
                else if (p == 4) scl_lo = 1'b0;
                else scl_lo = 1'b1;
            end
            i2cbb_pkg::OP_READ: begin
                if (p == 0) begin
                    sda_lo = 1'b0;
                    scl_lo = 1'b0;
                end else if (p == 1) begin
                    scl_lo = 1'b1;
                end else if (p == 2) begin
                    sda_lo = ~nack_r;
                end else begin
                    scl_lo = 1'b0;
                end
            end
            default: begin
                if (p == 0) begin
                    scl_lo = 1'b0;
                    sda_lo = 1'b0;
                end else if (p == 1) begin
                    scl_lo = 1'b1;
                end else if (p == 2) begin
                    scl_lo = 1'b0;
                end else if (p == 3) begin
                    sda_lo = 1'b1;
                end else if (p == 4) begin
                    scl_lo = 1'b0;
                end else if (p == 5) begin
                    sda_lo = 1'b0;
                end else begin
                    settle_cnt = settle_cfg;
                end
            end
        endcase
    endfunction

    // end of a timed phase, returns 1 when the operation is complete
    function automatic logic finish_phase(logic sda);
        case (eng_op)
            i2cbb_pkg::OP_START, i2cbb_pkg::OP_STOP: begin
                if (ph >= 2) return 1'b1;
                enter_phase(ph + 1);
            end
            i2cbb_pkg::OP_WRITE: begin
                if (ph == 2) begin
                    if (bit_idx < 7) begin
                        bit_idx++;
                        enter_phase(0);
                    end else begin
                        enter_phase(3);
                    end
                end else if (ph == 4) begin
                    ack_r = ~sda;
                    enter_phase(5);
                end else if (ph >= 5) begin
                    return 1'b1;
                end else begin
                    enter_phase(ph + 1);
                end
            end
            i2cbb_pkg::OP_READ: begin
                if (ph == 0) begin
                    shreg = {shreg[6:0], sda};
                    enter_phase(1);
                end else if (ph == 1) begin
                    if (bit_idx < 7) begin
                        bit_idx++;
                        enter_phase(0);
                    end else begin
                        enter_phase(2);
                    end
                end else if (ph == 2) begin
                    enter_phase(3);
                end else begin
                    scl_lo  = 1'b1;
                    sda_lo  = 1'b0;
                    rd_byte = shreg;
                    return 1'b1;
                end
            end
            default: begin
                if (ph == 0) begin
                    if (!sda) begin
                        pulses = '0;
                        enter_phase(1);
                    end else begin
                        enter_phase(3);
                    end
                end else if (ph == 2) begin
                    pulses++;
                    if (sda || pulses >= i2cbb_pkg::RECOVERY_PULSES_DEF) enter_phase(3);
                    else enter_phase(1);
                end else begin
                    enter_phase(ph + 1);
                end
            end
        endcase
        return 1'b0;
    endfunction

    // one tick of the engine, returns the packed bus result
    function automatic logic [15:0] engine_tick(logic [2:0] cmd, logic [7:0] data,
                                                logic nack, logic sda);
        logic done;
        done = 1'b0;
        if (eng_op == i2cbb_pkg::OP_IDLE) begin
            if (cmd >= CMD_START && cmd <= CMD_RECOVER) begin
                eng_op  = i2cbb_pkg::op_t'(cmd);
                bit_idx = '0;
                pulses  = '0;
                if (cmd == CMD_WRITE) shreg = data;
                if (cmd == CMD_READ) begin
                    shreg  = '0;
                    nack_r = nack;
                end
                enter_phase(0);
            end
        end else if (eng_op == i2cbb_pkg::OP_RECOVER && ph == i2cbb_pkg::PH_SETTLE) begin
            if (settle_cnt != 0) begin
                settle_cnt--;
            end else begin
                ok_r   = sda;
                eng_op = i2cbb_pkg::OP_IDLE;
                done   = 1'b1;
            end
        end else if (dly > 1) begin
            dly--;
        end else if (finish_phase(sda)) begin
            eng_op = i2cbb_pkg::OP_IDLE;
            ph     = '0;
            done   = 1'b1;
        end
        return {2'b00, ok_r, rd_byte, ack_r, done, eng_op != i2cbb_pkg::OP_IDLE,
                sda_lo, scl_lo};
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // random stalls of the result side
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest pending one
    always @(posedge aclk) begin : result_check
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (bus_result_q.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata, 16'h0);
            end else begin
                want = bus_result_q.pop_front();
                check_field("scl_drive_low", 16'(m_tdata[0]), 16'(want[0]));
                check_field("sda_drive_low", 16'(m_tdata[1]), 16'(want[1]));
                check_field("busy", 16'(m_tdata[2]), 16'(want[2]));
                check_field("done", 16'(m_tdata[3]), 16'(want[3]));
                check_field("ack_seen", 16'(m_tdata[4]), 16'(want[4]));
                check_field("read_data", 16'(m_tdata[12:5]), 16'(want[12:5]));
                check_field("bus_ok", 16'(m_tdata[13]), 16'(want[13]));
            end
        end
    end

    // one tick item, with an optional gap before it
    task automatic send_tick(input logic [2:0] cmd, input logic [7:0] data, input logic nack,
                             input logic sda, input bit typed, input logic [15:0] typed_res);
        logic [15:0] want;
        if (idle_en && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, sda, nack, data};
        do @(posedge aclk); while (!s_tready);
        want = engine_tick(cmd, data, nack, sda);
        bus_result_q.insert(bus_result_q.size(), typed ? typed_res : want);
        items_sent++;
    endtask

    // issue a command, then tick until the engine is idle again
    task automatic run_op(input logic [2:0] cmd, input logic [7:0] data, input logic nack,
                          input bit sda_rand, input int release_at, input bit noisy,
                          input bit typed, input logic [15:0] typed_res);
        int         n;
        logic [2:0] c;
        logic [7:0] d;
        logic       k;
        logic       sda;
        n = 0;
        c = cmd;
        d = data;
        k = nack;
        do begin
            sda = sda_rand ? 1'($urandom) : (n >= release_at);
            send_tick(c, d, k, sda, typed && n == 0, typed_res);
            n++;
            c = noisy ? 3'($urandom) : CMD_NONE;
            d = 8'($urandom);
            k = 1'($urandom);
        end while (eng_op != i2cbb_pkg::OP_IDLE);
    endtask

    task automatic wait_engine_idle();
        s_tvalid <= 1'b0;
        while (bus_result_q.size() != 0) @(posedge aclk);
    endtask

    // write both timing registers, unused upper bits randomized
    task automatic cfg_pair(input logic [15:0] half, input logic [23:0] settle);
        cfg_valid <= 1'b1;
        cfg_index <= i2cbb_pkg::REG_HALF_PERIOD;
        cfg_data  <= {8'($urandom), half};
        do @(posedge aclk); while (!cfg_ready);
        half_cfg = half;
        cfg_index <= i2cbb_pkg::REG_SETTLE;
        cfg_data  <= settle;
        do @(posedge aclk); while (!cfg_ready);
        settle_cfg = settle;
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed operations with random content and sda behavior
    task automatic run_random_op();
        logic [2:0] cmd;
        int         rel;
        bit         rnd;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_NONE;
                1: cmd = CMD_UNUSED_A;
                default: cmd = CMD_UNUSED_B;
            endcase
        end else begin
            cmd = 3'($urandom_range(CMD_START, CMD_RECOVER));
        end
        rnd = 1'b0;
        rel = NEVER_REL;
        if (cmd == CMD_RECOVER) begin
            case ($urandom_range(0, 2))
                0: rel = NEVER_REL;
                1: rel = $urandom_range(0, 80);
                default: rnd = 1'b1;
            endcase
        end else if ($urandom_range(0, 4) < 3) begin
            rnd = 1'b1;
        end else begin
            rel = $urandom_range(0, 30);
        end
        run_op(cmd, 8'($urandom), 1'($urandom), rnd, rel, $urandom_range(0, 3) == 0,
               1'b0, 16'h0);
    endtask

    initial begin : stimulus
        int          ops;
        int          start_items;
        logic [15:0] half;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].set_cfg) begin
                wait_engine_idle();
                cfg_pair(DIR_ROWS[i].half, DIR_ROWS[i].settle);
            end
            run_op(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].nack, DIR_ROWS[i].sda_rand,
                   DIR_ROWS[i].release_at, DIR_ROWS[i].noisy, DIR_ROWS[i].typed,
                   DIR_ROWS[i].typed_res);
        end

        // random operations, short half periods most of the time
        ops = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (ops % 6 == 0) begin
                wait_engine_idle();
                case ($urandom_range(0, 19))
                    0: half = 16'($urandom_range(5, 12));
                    1, 2, 3, 4, 5: half = 16'($urandom_range(2, 4));
                    default: half = 16'($urandom_range(0, 1));
                endcase
                cfg_pair(half, 24'($urandom_range(0, 8)));
            end
            run_random_op();
            ops++;
        end

        // no gaps or stalls from here on; widest timing registers written once
        wait_engine_idle();
        idle_en = 1'b0;
        while (stall_left != 0) @(posedge aclk);
        cfg_pair(16'hFFFF, 24'hFF_FFFF);
        run_op(CMD_NONE, 8'h00, 1'b0, 1'b1, 0, 1'b0, 1'b0, 16'h0);
        wait_engine_idle();
        cfg_pair(16'd1, 24'd2);
        repeat (8) run_random_op();

        wait_engine_idle();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/i2cbb_pkg.sv
rtl/i2c_bitbang_master_engine_core.sv
sim/i2c_bitbang_master_engine_core_tb.sv
